>>> rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    localparam int FUNC_BITS = 2;
    localparam int CAP_BITS  = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_GET        = 2'd0,
        FUNC_PUT        = 2'd1,
        FUNC_INVALIDATE = 2'd2,
        FUNC_NOP        = 2'd3
    } func_t;

endpackage

>>> rtl/lkvc_store.sv
// Slot storage with parallel key match, LRU age update and result formation.
module lkvc_store
    import lkvc_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int CNT_W      = $clog2(ENTRIES + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  func_t                 req_func,
    input  logic [KEY_BITS-1:0]   req_key,
    input  logic [VALUE_BITS-1:0] req_value,
    input  logic [CAP_BITS-1:0]   capacity,
    output logic                  res_hit,
    output logic [VALUE_BITS-1:0] res_read_value,
    output logic                  res_released_valid,
    output logic [VALUE_BITS-1:0] res_released_value,
    output logic [CNT_W-1:0]      res_entry_count
);

    localparam int AGE_W = $clog2(ENTRIES);
    localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    logic [ENTRIES-1:0]    slot_valid_reg, slot_valid_next;
    logic [AGE_W-1:0]      slot_age_reg   [ENTRIES];
    logic [AGE_W-1:0]      slot_age_next  [ENTRIES];
    logic [KEY_BITS-1:0]   slot_key_reg   [ENTRIES];
    logic [KEY_BITS-1:0]   slot_key_next  [ENTRIES];
    logic [VALUE_BITS-1:0] slot_value_reg [ENTRIES];
    logic [VALUE_BITS-1:0] slot_value_next[ENTRIES];
    logic [CNT_W-1:0]      live_count_reg, live_count_next;

    logic [ENTRIES-1:0]    hit_vec;
    logic [ENTRIES-1:0]    victim_vec;
    logic [ENTRIES-1:0]    avail_vec;
    logic [ENTRIES-1:0]    free_vec;
    logic                  any_hit;
    logic [AGE_W-1:0]      hit_age;
    logic [AGE_W-1:0]      oldest_age;
    logic [VALUE_BITS-1:0] hit_value;
    logic [VALUE_BITS-1:0] victim_value;
    logic [CMP_W-1:0]      cap_raw;
    logic [CMP_W-1:0]      cap_eff;
    logic                  evict;
    logic [CNT_W-1:0]      live_minus_one;

    assign live_minus_one = live_count_reg - CNT_W'(1);
    assign oldest_age     = live_minus_one[AGE_W-1:0];

    // Zero is raised to one and anything above the slot count is lowered to it.
    assign cap_raw = CMP_W'(capacity);
    always_comb
    begin
        if (cap_raw == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_raw > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_raw;
        end
    end

    assign evict = (CMP_W'(live_count_reg) >= cap_eff);

    // Keys are unique among live slots, so at most one slot matches. The live
    // ages are distinct, and the oldest entry carries age live_count - 1.
    always_comb
    begin
        hit_age      = '0;
        hit_value    = '0;
        victim_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i]    = slot_valid_reg[i] && (slot_key_reg[i] == req_key)
                            && (req_func != FUNC_NOP);
            victim_vec[i] = slot_valid_reg[i] && (slot_age_reg[i] == oldest_age);
            if (hit_vec[i])
            begin
                hit_age   = hit_age | slot_age_reg[i];
                hit_value = hit_value | slot_value_reg[i];
            end
            if (victim_vec[i])
            begin
                victim_value = victim_value | slot_value_reg[i];
            end
        end
    end

    assign any_hit = |hit_vec;

    // The lowest free slot, counting the victim as free when one is evicted.
    assign avail_vec = ~slot_valid_reg | (evict ? victim_vec : '0);
    assign free_vec  = avail_vec & (~avail_vec + ENTRIES'(1));

    always_comb
    begin
        slot_valid_next    = slot_valid_reg;
        slot_age_next      = slot_age_reg;
        slot_key_next      = slot_key_reg;
        slot_value_next    = slot_value_reg;
        live_count_next    = live_count_reg;
        res_read_value     = '0;
        res_released_valid = 1'b0;
        res_released_value = '0;

        unique case (req_func) inside
            FUNC_GET, FUNC_PUT:
            begin
                if (any_hit)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (hit_vec[i])
                        begin
                            slot_age_next[i] = '0;
                            if (req_func == FUNC_PUT)
                            begin
                                slot_value_next[i] = req_value;
                            end
                        end
                        else if (slot_valid_reg[i] && (slot_age_reg[i] < hit_age))
                        begin
                            slot_age_next[i] = slot_age_reg[i] + AGE_W'(1);
                        end
                    end
                    if (req_func == FUNC_GET)
                    begin
                        res_read_value = hit_value;
                    end
                    else
                    begin
                        res_released_valid = 1'b1;
                        res_released_value = hit_value;
                    end
                end
                else if (req_func == FUNC_PUT)
                begin
                    // The victim is the oldest entry, so no survivor ages down;
                    // every survivor ages by one behind the new entry.
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (free_vec[i])
                        begin
                            slot_valid_next[i] = 1'b1;
                            slot_age_next[i]   = '0;
                            slot_key_next[i]   = req_key;
                            slot_value_next[i] = req_value;
                        end
                        else if (evict && victim_vec[i])
                        begin
                            slot_valid_next[i] = 1'b0;
                            slot_age_next[i]   = '0;
                        end
                        else if (slot_valid_reg[i])
                        begin
                            slot_age_next[i] = slot_age_reg[i] + AGE_W'(1);
                        end
                    end
                    if (evict)
                    begin
                        res_released_valid = 1'b1;
                        res_released_value = victim_value;
                    end
                    else
                    begin
                        live_count_next = live_count_reg + CNT_W'(1);
                    end
                end
            end
            FUNC_INVALIDATE:
            begin
                if (any_hit)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (hit_vec[i])
                        begin
                            slot_valid_next[i] = 1'b0;
                            slot_age_next[i]   = '0;
                        end
                        else if (slot_valid_reg[i] && (slot_age_reg[i] > hit_age))
                        begin
                            slot_age_next[i] = slot_age_reg[i] - AGE_W'(1);
                        end
                    end
                    live_count_next    = live_minus_one;
                    res_released_valid = 1'b1;
                    res_released_value = hit_value;
                end
            end
            FUNC_NOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign res_hit         = any_hit;
    assign res_entry_count = live_count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            live_count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_age_reg[i] <= '0;
            end
        end
        else if (req_valid)
        begin
            slot_valid_reg <= slot_valid_next;
            live_count_reg <= live_count_next;
            slot_age_reg   <= slot_age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            slot_key_reg   <= slot_key_next;
            slot_value_reg <= slot_value_next;
        end
    end

endmodule

>>> rtl/lru_key_value_cache_top.sv
// Fully associative LRU key/value cache: one request per cycle. A request
// taken at a rising edge is held in the input register while every slot
// compares its key in parallel and the ages, slots and live count are
// updated; its result is loaded at the next edge and shown with done for
// exactly one cycle. busy never rises, so a new request may be started in
// every cycle, and the receiver must take each result transfer in the cycle
// that done is high. The parallel compare and age update over all slots sets
// this rate. The user must write capacity_limit through cfg_write and cfg_data
// only while no request is in flight; the block itself does not enforce this.
module lru_key_value_cache_top
    import lkvc_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int CNT_W      = $clog2(ENTRIES + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CAP_BITS-1:0]   cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [FUNC_BITS-1:0]  func,
    input  logic [KEY_BITS-1:0]   lookup_key,
    input  logic [VALUE_BITS-1:0] new_value,
    output logic                  done,
    output logic                  hit,
    output logic [VALUE_BITS-1:0] read_value,
    output logic                  released_valid,
    output logic [VALUE_BITS-1:0] released_value,
    output logic [CNT_W-1:0]      entry_count
);

    logic [CAP_BITS-1:0]   capacity_reg;
    logic                  req_valid_reg;
    func_t                 func_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    logic                  res_hit;
    logic [VALUE_BITS-1:0] res_read_value;
    logic                  res_released_valid;
    logic [VALUE_BITS-1:0] res_released_value;
    logic [CNT_W-1:0]      res_entry_count;

    logic                  done_reg;
    logic                  hit_reg;
    logic [VALUE_BITS-1:0] read_value_reg;
    logic                  released_valid_reg;
    logic [VALUE_BITS-1:0] released_value_reg;
    logic [CNT_W-1:0]      entry_count_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                capacity_reg <= cfg_data;
            end
            req_valid_reg <= start && !busy;
            done_reg      <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            func_reg  <= func_t'(func);
            key_reg   <= lookup_key;
            value_reg <= new_value;
        end
        if (req_valid_reg)
        begin
            hit_reg            <= res_hit;
            read_value_reg     <= res_read_value;
            released_valid_reg <= res_released_valid;
            released_value_reg <= res_released_value;
            entry_count_reg    <= res_entry_count;
        end
    end

    lkvc_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W)
    ) u_store (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_valid          (req_valid_reg),
        .req_func           (func_reg),
        .req_key            (key_reg),
        .req_value          (value_reg),
        .capacity           (capacity_reg),
        .res_hit            (res_hit),
        .res_read_value     (res_read_value),
        .res_released_valid (res_released_valid),
        .res_released_value (res_released_value),
        .res_entry_count    (res_entry_count)
    );

    assign done           = done_reg;
    assign hit            = hit_reg;
    assign read_value     = read_value_reg;
    assign released_valid = released_valid_reg;
    assign released_value = released_value_reg;
    assign entry_count    = entry_count_reg;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the LRU key/value cache: directed table, then random phases.
module testbench;
    import lkvc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = DEF_ENTRIES;
    localparam int RANDOM_OPS  = 1050;
    localparam int STALL_LIMIT = 400;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        released_valid;
        logic [31:0] released_value;
        logic [4:0]  entry_count;
    } cache_result_t;

    typedef struct packed {
        logic          is_cfg;
        func_t         op;
        logic [31:0]   key;
        logic [31:0]   value;
        logic          typed;
        cache_result_t want;
    } step_row_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [CAP_BITS-1:0] cfg_data = '0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          func = '0;
    logic [31:0]         lookup_key = '0;
    logic [31:0]         new_value = '0;
    logic                done;
    logic                hit;
    logic [31:0]         read_value;
    logic                released_valid;
    logic [31:0]         released_value;
    logic [4:0]          entry_count;

    // Shadow copy of the cache contents and recency order.
    logic                slot_used [SLOTS];
    logic [31:0]         slot_tag  [SLOTS];
    logic [31:0]         slot_data [SLOTS];
    int                  slot_rank [SLOTS];
    int                  live_entries;
    logic [CAP_BITS-1:0] capacity_reg;

    cache_result_t awaited_results[$];
    step_row_t     directed_rows[$];

    int mismatch_count;
    int items_sent;
    int results_seen;
    int hit_count;
    int release_count;
    int cfg_writes;
    int idle_cycles;

    lru_key_value_cache_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .lookup_key     (lookup_key),
        .new_value      (new_value),
        .done           (done),
        .hit            (hit),
        .read_value     (read_value),
        .released_valid (released_valid),
        .released_value (released_value),
        .entry_count    (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic cache_result_t result_of(logic h, logic [31:0] rd, logic rv,
                                                logic [31:0] rval, logic [4:0] cnt);
        cache_result_t r;
        r.hit            = h;
        r.read_value     = rd;
        r.released_valid = rv;
        r.released_value = rval;
        r.entry_count    = cnt;
        return r;
    endfunction

    function automatic void add_row(logic is_cfg, func_t op, logic [31:0] key,
                                    logic [31:0] value, logic typed, cache_result_t want);
        step_row_t row;
        row.is_cfg = is_cfg;
        row.op     = op;
        row.key    = key;
        row.value  = value;
        row.typed  = typed;
        row.want   = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void promote_slot(int s);
        int a;
        a = slot_rank[s];
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && i != s && slot_rank[i] < a)
                slot_rank[i]++;
        slot_rank[s] = 0;
    endfunction

    function automatic void remove_slot(int s);
        int a;
        a = slot_rank[s];
        slot_used[s] = 1'b0;
        slot_rank[s] = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_rank[i] > a)
                slot_rank[i]--;
        if (live_entries > 0)
            live_entries--;
    endfunction

    // Applies one request to the shadow cache and returns the result it should produce.
    function automatic cache_result_t cache_access_outcome(func_t op, logic [31:0] key,
                                                          logic [31:0] value);
        cache_result_t r;
        int s;
        int victim;
        int oldest;
        int free_slot;
        int eff_cap;
        r = '0;
        s = -1;
        victim = -1;
        oldest = 0;
        free_slot = -1;
        eff_cap = (capacity_reg == 0) ? 1 : (capacity_reg > SLOTS) ? SLOTS : int'(capacity_reg);
        if (op != FUNC_NOP)
            for (int i = 0; i < SLOTS; i++)
                if (s < 0 && slot_used[i] && slot_tag[i] == key)
                    s = i;
        r.hit = (s >= 0);
        case (op)
            FUNC_GET:
            begin
                if (s >= 0)
                begin
                    r.read_value = slot_data[s];
                    promote_slot(s);
                end
            end
            FUNC_PUT:
            begin
                if (s >= 0)
                begin
                    r.released_valid = 1'b1;
                    r.released_value = slot_data[s];
                    slot_data[s] = value;
                    promote_slot(s);
                end
                else
                begin
                    // A full table (or one over a lowered limit) gives up its oldest entry.
                    if (live_entries >= eff_cap)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                            if (slot_used[i] && (victim < 0 || slot_rank[i] > oldest))
                            begin
                                victim = i;
                                oldest = slot_rank[i];
                            end
                        if (victim >= 0)
                        begin
                            r.released_valid = 1'b1;
                            r.released_value = slot_data[victim];
                            remove_slot(victim);
                        end
                    end
                    for (int i = 0; i < SLOTS; i++)
                        if (free_slot < 0 && !slot_used[i])
                            free_slot = i;
                    if (free_slot >= 0)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                            if (slot_used[i])
                                slot_rank[i]++;
                        slot_used[free_slot] = 1'b1;
                        slot_tag[free_slot]  = key;
                        slot_data[free_slot] = value;
                        slot_rank[free_slot] = 0;
                        live_entries++;
                    end
                end
            end
            FUNC_INVALIDATE:
            begin
                if (s >= 0)
                begin
                    r.released_valid = 1'b1;
                    r.released_value = slot_data[s];
                    remove_slot(s);
                end
            end
            default: ;
        endcase
        r.entry_count = live_entries[4:0];
        return r;
    endfunction

    // Presents one request after a gap and holds it until the transfer happens.
    task automatic issue_request(func_t op, logic [31:0] key, logic [31:0] value, int gap,
                                 logic typed, cache_result_t want);
        cache_result_t predicted;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        func       <= op;
        lookup_key <= key;
        new_value  <= value;
        do
            @(posedge clk);
        while (busy);
        predicted = cache_access_outcome(op, key, value);
        awaited_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_BITS-1:0] cap);
        drain_results();
        cfg_write <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        cfg_write <= 1'b0;
        capacity_reg = cap;
        cfg_writes++;
    endtask

    function automatic int draw_gap(int mode);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return $urandom_range(0, 13);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
    endfunction

    always @(posedge clk)
    begin : check_results
        cache_result_t got;
        cache_result_t want;
        if (rst_n && done)
        begin
            got = result_of(hit, read_value, released_valid, released_value, entry_count);
            results_seen++;
            if (got.hit)
                hit_count++;
            if (got.released_valid)
                release_count++;
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: result transfer with nothing outstanding: hit=%0b rd=%h",
                             got.hit, got.read_value);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.hit !== want.hit || got.read_value !== want.read_value ||
                    got.released_valid !== want.released_valid ||
                    got.released_value !== want.released_value ||
                    got.entry_count !== want.entry_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"ERROR: result %0d expected hit=%0b rd=%h rel=%0b relv=%h ",
                                  "cnt=%0d, got hit=%0b rd=%h rel=%0b relv=%h cnt=%0d"},
                                 results_seen, want.hit, want.read_value,
                                 want.released_valid, want.released_value, want.entry_count,
                                 got.hit, got.read_value, got.released_valid,
                                 got.released_value, got.entry_count);
                end
            end
        end
    end

    // Ends the run if neither side transfers anything for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [31:0] key_pool [20];
        int          phase_caps [10];
        int          counted;
        int          span;
        int          mode;
        int          pick;
        func_t       op;
        logic [31:0] key;
        logic [31:0] value;
        int          eff;

        mismatch_count = 0;
        items_sent = 0;
        results_seen = 0;
        hit_count = 0;
        release_count = 0;
        cfg_writes = 0;
        idle_cycles = 0;
        live_entries = 0;
        capacity_reg = CAP_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            slot_tag[i]  = '0;
            slot_data[i] = '0;
            slot_rank[i] = 0;
        end

        // Misses on an empty table, the unused selector, and all-zero/all-one keys and values.
        add_row(0, FUNC_GET,        32'h0000_0000, 32'h0000_0000, 1, result_of(0, 0, 0, 0, 0));
        add_row(0, FUNC_INVALIDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, result_of(0, 0, 0, 0, 0));
        add_row(0, FUNC_NOP,        32'hA5A5_A5A5, 32'h5A5A_5A5A, 1, result_of(0, 0, 0, 0, 0));
        add_row(0, FUNC_PUT,        32'h0000_0000, 32'hFFFF_FFFF, 1, result_of(0, 0, 0, 0, 1));
        add_row(0, FUNC_PUT,        32'hFFFF_FFFF, 32'h0000_0000, 1, result_of(0, 0, 0, 0, 2));
        add_row(0, FUNC_GET,        32'h0000_0000, 32'h1234_5678, 1,
                result_of(1, 32'hFFFF_FFFF, 0, 0, 2));
        add_row(0, FUNC_GET,        32'hFFFF_FFFF, 32'h0, 1, result_of(1, 0, 0, 0, 2));
        add_row(0, FUNC_PUT,        32'h0000_0000, 32'h1234_5678, 1,
                result_of(1, 0, 1, 32'hFFFF_FFFF, 2));
        add_row(0, FUNC_INVALIDATE, 32'hFFFF_FFFF, 32'h0, 1, result_of(1, 0, 1, 0, 1));
        add_row(0, FUNC_NOP,        32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, result_of(0, 0, 0, 0, 1));
        // A zero limit acts as one: a new key pushes out the only entry.
        add_row(1, FUNC_NOP,        32'h0, 32'd0, 0, '0);
        add_row(0, FUNC_PUT,        32'h0000_0005, 32'hAAAA_5555, 1,
                result_of(0, 0, 1, 32'h1234_5678, 1));
        add_row(0, FUNC_PUT,        32'h0000_0005, 32'h5555_AAAA, 1,
                result_of(1, 0, 1, 32'hAAAA_5555, 1));
        add_row(1, FUNC_NOP,        32'h0, 32'd2, 0, '0);
        add_row(0, FUNC_PUT,        32'h0000_0007, 32'h0000_0077, 0, '0);
        add_row(0, FUNC_PUT,        32'h0000_0008, 32'h0000_0088, 0, '0);
        add_row(0, FUNC_GET,        32'h0000_0007, 32'h0, 0, '0);
        add_row(0, FUNC_PUT,        32'h0000_0009, 32'h0000_0099, 0, '0);
        // A limit above the table size is clipped to the table size.
        add_row(1, FUNC_NOP,        32'h0, 32'd31, 0, '0);
        add_row(0, FUNC_PUT,        32'h0000_FFFF, 32'hFFFF_0000, 0, '0);
        add_row(0, FUNC_PUT,        32'hFFFF_0000, 32'h0000_FFFF, 0, '0);
        // Lowering the limit below the live count keeps the count until invalidates.
        add_row(1, FUNC_NOP,        32'h0, 32'd1, 0, '0);
        add_row(0, FUNC_PUT,        32'h0000_0011, 32'h1111_1111, 0, '0);
        add_row(0, FUNC_INVALIDATE, 32'h0000_0007, 32'h0, 0, '0);
        add_row(0, FUNC_GET,        32'hDEAD_BEEF, 32'h0, 0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_capacity(directed_rows[i].value[CAP_BITS-1:0]);
            else
                issue_request(directed_rows[i].op, directed_rows[i].key,
                              directed_rows[i].value, $urandom_range(0, 3),
                              directed_rows[i].typed, directed_rows[i].want);
        end

        phase_caps = '{16, 4, 1, 31, 0, 9, 2, 16, 5, 12};
        counted = 0;
        for (int p = 0; p < 10; p++)
        begin
            write_capacity(phase_caps[p][CAP_BITS-1:0]);
            eff = (phase_caps[p] == 0) ? 1 : (phase_caps[p] > SLOTS) ? SLOTS : phase_caps[p];
            span = (eff + 3 > 19) ? 19 : eff + 3;
            for (int i = 0; i < 20; i++)
                key_pool[i] = $urandom;
            mode = 0;
            while (counted < (p + 1) * RANDOM_OPS / 10)
            begin
                if (counted % 24 == 0)
                    mode = $urandom_range(0, 2);
                // Now and then the sender waits for every outstanding result.
                if ($urandom_range(0, 63) == 0)
                    drain_results();
                pick = $urandom_range(0, 99);
                op = (pick < 40) ? FUNC_PUT : (pick < 75) ? FUNC_GET :
                     (pick < 92) ? FUNC_INVALIDATE : FUNC_NOP;
                key = ($urandom_range(0, 11) == 0) ? $urandom
                                                   : key_pool[$urandom_range(0, span)];
                pick = $urandom_range(0, 15);
                value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
                issue_request(op, key, value, draw_gap(mode), 1'b0, '0);
                counted++;
            end
        end

        drain_results();
        $display("Sent %0d requests over %0d capacity settings; %0d results checked.",
                 items_sent, cfg_writes, results_seen);
        $display("Results with a hit: %0d, with a released value: %0d, mismatches: %0d.",
                 hit_count, release_count, mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
